@@ hw/rtl/assert_macros.svh @@
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
    else $error("assertion failed");

`endif

@@ hw/rtl/qsld_pkg.sv @@
package qsld_pkg;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned MaxResults = 3;

  localparam logic [7:0] CharQuote  = 8'h22;
  localparam logic [7:0] CharBslash = 8'h5C;
  localparam logic [7:0] CharN      = 8'h6E;
  localparam logic [7:0] CharT      = 8'h74;
  localparam logic [7:0] CharR      = 8'h72;
  localparam logic [7:0] CharLf     = 8'h0A;
  localparam logic [7:0] CharTab    = 8'h09;
  localparam logic [7:0] CharCr     = 8'h0D;

  localparam logic [2:0] PhIdle = 3'd0;
  localparam logic [2:0] PhOneQ = 3'd1;
  localparam logic [2:0] PhTwoQ = 3'd2;
  localparam logic [2:0] PhReg  = 3'd3;
  localparam logic [2:0] PhTri  = 3'd4;
  localparam logic [2:0] PhTri1 = 3'd5;
  localparam logic [2:0] PhTri2 = 3'd6;

  localparam logic [2:0] StData   = 3'd0;
  localparam logic [2:0] StDone   = 3'd1;
  localparam logic [2:0] StNotLit = 3'd2;
  localparam logic [2:0] StUnterm = 3'd3;
  localparam logic [2:0] StLimit  = 3'd4;

  localparam logic [31:0] UsageLimitReset = 32'hFFFF_FFFF;

  typedef struct packed {
    logic       action;
    logic [7:0] in_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic [2:0]  status;
    logic [31:0] literal_length;
    logic        byte_pushed_back;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [2:0]  phase;
    logic        esc;
    logic [31:0] len;
    logic [32:0] usage;
  } scan_state_t;

endpackage

@@ hw/rtl/quoted_string_literal_decoder_top.sv @@
// quoted string literal decoder
// input channel: in_valid_i / in_stall_o / in_item_i, one text byte or an
//   end-of-stream mark per item
// output channel: out_valid_o / out_stall_i / out_item_o, zero to three
//   result items per input item, the final one flagged by last
// config channel: cfg_valid_i / cfg_ready_o / cfg_data_i writes the usage
//   limit; cfg_ready_o is always high, write only while the block is idle
// an accepted item is held in the input register, decoded in one pass by
//   the combinational core, and its results land in a small result queue
//   whose head drives the output
// throughput is one item per cycle while each item gives at most one
//   result and the receiver does not stall; the results of one item leave
//   in turn through the single-entry read of the result queue
// reset clears the scan state, the usage total and the queue, and sets the
//   limit to all ones
// when the receiver stalls, results wait in the queue; once it has no room
//   for three more results the input register holds and in_stall_o rises
module quoted_string_literal_decoder_top #(
  parameter int unsigned QueueDepth = qsld_pkg::QueueDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  qsld_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output qsld_pkg::out_item_t out_item_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [31:0]         cfg_data_i
);

  logic                  in_valid_q, in_valid_d;
  qsld_pkg::in_item_t    in_item_q;
  qsld_pkg::scan_state_t state_q, state_d, state_n;
  logic [31:0]           limit_q;
  logic                  room;
  logic                  proc;
  logic                  accept;
  qsld_pkg::out_item_t [qsld_pkg::MaxResults-1:0] res;
  logic [1:0]            res_cnt;

  assign cfg_ready_o = 1'b1;
  assign proc        = in_valid_q & room;
  assign in_stall_o  = in_valid_q & ~room;
  assign accept      = in_valid_i & ~in_stall_o;
  assign in_valid_d  = accept | (in_valid_q & ~proc);
  assign state_d     = proc ? state_n : state_q;

  qsld_core u_core (
    .state_i   (state_q),
    .item_i    (in_item_q),
    .limit_i   (limit_q),
    .state_o   (state_n),
    .res_o     (res),
    .res_cnt_o (res_cnt)
  );

  qsld_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (res),
    .wr_cnt_i (proc ? res_cnt : 2'd0),
    .room_o   (room),
    .valid_o  (out_valid_o),
    .pop_i    (~out_stall_i),
    .head_o   (out_item_o)
  );

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_item_q <= in_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      state_q    <= '0;
      limit_q    <= qsld_pkg::UsageLimitReset;
    end else begin
      in_valid_q <= in_valid_d;
      state_q    <= state_d;
      if (cfg_valid_i) begin
        limit_q <= cfg_data_i;
      end
    end
  end

endmodule

@@ hw/rtl/qsld_core.sv @@
module qsld_core (
  input  qsld_pkg::scan_state_t                  state_i,
  input  qsld_pkg::in_item_t                     item_i,
  input  logic [31:0]                            limit_i,
  output qsld_pkg::scan_state_t                  state_o,
  output qsld_pkg::out_item_t [qsld_pkg::MaxResults-1:0] res_o,
  output logic [1:0]                             res_cnt_o
);

  function automatic logic [7:0] unescape(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c == qsld_pkg::CharN) r = qsld_pkg::CharLf;
    else if (c == qsld_pkg::CharT) r = qsld_pkg::CharTab;
    else if (c == qsld_pkg::CharR) r = qsld_pkg::CharCr;
    return r;
  endfunction

  logic [1:0]  ndata;
  logic [7:0]  dbyte [qsld_pkg::MaxResults];
  logic        fin;
  logic        misc;
  logic        pb;
  logic [2:0]  mst;
  logic        do_reg;
  logic        clr;
  logic        lit_open;
  logic [7:0]  c;
  logic        is_q;
  logic [32:0] len_sum;
  logic [33:0] use_sum;
  logic [32:0] use_sat;
  logic [1:0]  cnt;
  qsld_pkg::out_item_t fin_res;

  always_comb begin
    c       = item_i.in_byte;
    is_q    = (c == qsld_pkg::CharQuote);
    ndata   = 2'd0;
    dbyte[0] = c;
    dbyte[1] = c;
    dbyte[2] = c;
    fin     = 1'b0;
    misc    = 1'b0;
    pb      = 1'b0;
    mst     = qsld_pkg::StNotLit;
    do_reg  = 1'b0;
    clr     = 1'b0;
    lit_open = 1'b0;
    state_o = state_i;

    if (item_i.action) begin
      unique case (state_i.phase)
        qsld_pkg::PhIdle: begin
          misc = 1'b1;
          mst  = qsld_pkg::StNotLit;
        end
        qsld_pkg::PhTwoQ: fin = 1'b1;
        default: begin
          misc = 1'b1;
          mst  = qsld_pkg::StUnterm;
          clr  = 1'b1;
        end
      endcase
    end else begin
      unique case (state_i.phase)
        qsld_pkg::PhIdle: begin
          if (is_q) begin
            lit_open = 1'b1;
            clr = 1'b1;
          end else begin
            misc = 1'b1;
            mst  = qsld_pkg::StNotLit;
            pb   = 1'b1;
          end
        end
        qsld_pkg::PhOneQ: begin
          if (is_q) state_o.phase = qsld_pkg::PhTwoQ;
          else do_reg = 1'b1;
        end
        qsld_pkg::PhTwoQ: begin
          if (is_q) begin
            state_o.phase = qsld_pkg::PhTri;
          end else begin
            fin = 1'b1;
            pb  = 1'b1;
          end
        end
        qsld_pkg::PhReg: do_reg = 1'b1;
        qsld_pkg::PhTri: begin
          if (is_q) state_o.phase = qsld_pkg::PhTri1;
          else ndata = 2'd1;
        end
        qsld_pkg::PhTri1: begin
          if (is_q) begin
            state_o.phase = qsld_pkg::PhTri2;
          end else begin
            ndata    = 2'd2;
            dbyte[0] = qsld_pkg::CharQuote;
            dbyte[1] = c;
            state_o.phase = qsld_pkg::PhTri;
          end
        end
        qsld_pkg::PhTri2: begin
          if (is_q) begin
            fin = 1'b1;
          end else begin
            ndata    = 2'd3;
            dbyte[0] = qsld_pkg::CharQuote;
            dbyte[1] = qsld_pkg::CharQuote;
            dbyte[2] = c;
            state_o.phase = qsld_pkg::PhTri;
          end
        end
        default: clr = 1'b1;
      endcase
    end

    if (do_reg) begin
      state_o.phase = qsld_pkg::PhReg;
      if (state_i.esc) begin
        state_o.esc = 1'b0;
        ndata       = 2'd1;
        dbyte[0]    = unescape(c);
      end else if (c == qsld_pkg::CharBslash) begin
        state_o.esc = 1'b1;
      end else if (is_q) begin
        fin = 1'b1;
      end else begin
        ndata = 2'd1;
      end
    end

    use_sum = {1'b0, state_i.usage} + {2'b00, state_i.len};
    use_sat = use_sum[33] ? '1 : use_sum[32:0];
    if (fin) begin
      clr           = 1'b1;
      state_o.usage = use_sat;
    end

    len_sum = {1'b0, state_i.len} + {31'd0, ndata};
    if (clr) begin
      state_o.phase = lit_open ? qsld_pkg::PhOneQ : qsld_pkg::PhIdle;
      state_o.esc = 1'b0;
      state_o.len = '0;
    end else begin
      state_o.len = len_sum[32] ? '1 : len_sum[31:0];
    end

    fin_res.out_byte         = 8'd0;
    fin_res.status           = mst;
    fin_res.literal_length   = 32'd0;
    fin_res.byte_pushed_back = pb;
    fin_res.last             = 1'b1;
    if (fin) begin
      fin_res.status         = (use_sat > {1'b0, limit_i}) ? qsld_pkg::StLimit
                                                           : qsld_pkg::StDone;
      fin_res.literal_length = state_i.len;
    end

    cnt = ndata + {1'b0, (fin | misc)};
    for (int j = 0; j < qsld_pkg::MaxResults; j++) begin
      res_o[j] = '0;
      if (2'(j) < ndata) begin
        res_o[j].out_byte = dbyte[j];
        res_o[j].status   = qsld_pkg::StData;
        res_o[j].last     = (2'(j) == cnt - 2'd1);
      end else if (2'(j) == ndata) begin
        res_o[j] = fin_res;
      end
    end
    res_cnt_o = cnt;
  end

endmodule

@@ hw/rtl/qsld_queue.sv @@
module qsld_queue #(
  parameter int unsigned Depth = qsld_pkg::QueueDepth
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  qsld_pkg::out_item_t [qsld_pkg::MaxResults-1:0] wr_i,
  input  logic [1:0]                             wr_cnt_i,
  output logic                                   room_o,
  output logic                                   valid_o,
  input  logic                                   pop_i,
  output qsld_pkg::out_item_t                    head_o
);

  localparam int unsigned CntW = $clog2(Depth + 1);

  qsld_pkg::out_item_t entry_q [Depth];
  qsld_pkg::out_item_t entry_d [Depth];
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] base;
  logic            pop;

  assign valid_o = (count_q != '0);
  assign pop     = pop_i & valid_o;
  assign room_o  = (count_q <= CntW'(Depth - qsld_pkg::MaxResults));
  assign head_o  = entry_q[0];

  always_comb begin
    base    = count_q - {{(CntW-1){1'b0}}, pop};
    count_d = base + CntW'(wr_cnt_i);
    for (int i = 0; i < Depth; i++) begin
      entry_d[i] = entry_q[i];
      if (pop && (i + 1 < Depth)) entry_d[i] = entry_q[i + 1];
      for (int j = 0; j < qsld_pkg::MaxResults; j++) begin
        if ((2'(j) < wr_cnt_i) && (base + CntW'(j) == CntW'(i))) entry_d[i] = wr_i[j];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

endmodule

@@ hw/rtl/qsld_checker.sv @@
`include "assert_macros.svh"

module qsld_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input qsld_pkg::out_item_t out_item_o
);

  `ASSERT_NEXT(out_hold_a, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)
  `ASSERT_NEXT(out_stable_a, clk_i, rst_ni, out_valid_o && out_stall_i, $stable(out_item_o))
  `ASSERT_IMPLIES(reset_quiet_a, clk_i, rst_ni, !$past(rst_ni), !out_valid_o)
  `ASSERT_IMPLIES(data_clean_a, clk_i, rst_ni, out_valid_o && out_item_o.status == qsld_pkg::StData, out_item_o.literal_length == 32'd0 && !out_item_o.byte_pushed_back)

endmodule

bind quoted_string_literal_decoder_top qsld_checker u_qsld_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);
